@@ rtl/core/tccw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console character writer package
// Shared widths, codes, payload structs and the command type passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Field widths.
  localparam int OP_W       = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int POS_W      = 11;
  localparam int ATTR_W     = 8;
  localparam int TAB_W      = 4;
  localparam int PROT_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Depth of the command queue between front and back end.
  localparam int QUEUE_DEPTH = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECTED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTRIBUTE = 2'd2;

  // Configuration reset values.
  localparam logic [TAB_W-1:0]  TAB_RESET  = 4'd4;
  localparam logic [PROT_W-1:0] PROT_RESET = 7'd16;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attribute;
  } result_t;

  typedef struct packed {
    logic [TAB_W-1:0]  tab_width;
    logic [PROT_W-1:0] protected_columns;
    logic [ATTR_W-1:0] text_attribute;
  } cfg_t;

  // Classified command kinds.
  typedef enum logic [2:0] {
    KIND_PRINT     = 3'd0,
    KIND_BACKSPACE = 3'd1,
    KIND_RETURN    = 3'd2,
    KIND_TAB       = 3'd3,
    KIND_NEWLINE   = 3'd4,
    KIND_READ      = 3'd5,
    KIND_CLEAR     = 3'd6,
    KIND_NOP       = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/tccw_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tccw_front.sv @@
// ----------------------------------------------------------------------------
// Text console front end
// Accepts input beats, classifies each into a command and holds it in a short
// queue until the back end takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tccw_front import tccw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept_en,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  cmd_valid,
  input  logic  cmd_ready,
  output cmd_t  cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  // Map an input item to the command the back end carries out.
  function automatic cmd_t classify(input item_t it);
    cmd_t c;
    c.char_code  = it.char_code;
    c.cell_index = it.cell_index;
    c.kind       = KIND_NOP;
    if (it.operation == OP_PUT) begin
      unique case (it.char_code)
        CH_BACKSPACE: c.kind = KIND_BACKSPACE;
        CH_RETURN:    c.kind = KIND_RETURN;
        CH_TAB:       c.kind = KIND_TAB;
        CH_NEWLINE:   c.kind = KIND_NEWLINE;
        default:      c.kind = KIND_PRINT;
      endcase
    end else if (it.operation == OP_READ) begin
      c.kind = KIND_READ;
    end else if (it.operation == OP_CLEAR) begin
      c.kind = KIND_CLEAR;
    end
    return c;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Handshakes on both sides of the queue.
  assign item_ready = accept_en && (count != CNT_W'(QUEUE_DEPTH));
  assign push       = item_valid && item_ready;
  assign cmd_valid  = (count != '0);
  assign pop        = cmd_valid && cmd_ready;
  assign cmd        = q_mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= classify(item);
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tccw_back.sv @@
// ----------------------------------------------------------------------------
// Text console back end
// Holds the cursor and the screen memory, carries out queued commands,
// including the row copy for scrolling, the screen clear and the backspace
// search, and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tccw_back import tccw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  cmd_t    cmd,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result,
  output logic    accept_en
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PTR_W  = ADDR_W + 1;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int C_W    = COL_W + 1;
  localparam int CX_W   = (C_W > PROT_W) ? C_W : PROT_W;
  localparam int CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_SWEEP  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t state, state_next;

  // Cursor.
  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;

  // Backspace search.
  logic [COL_W-1:0] scan_col, scan_col_next;
  logic [COL_W-1:0] scan_low, scan_low_next;

  // Memory sweep for scroll, clear and the reset pass.
  logic [PTR_W-1:0]  sw_ptr, sw_ptr_next;
  logic              sw_wr_valid, sw_wr_valid_next;
  logic [ADDR_W-1:0] sw_wr_addr, sw_wr_addr_next;
  logic              sw_wr_copy, sw_wr_copy_next;
  logic              sw_scroll, sw_scroll_next;
  logic              sw_result, sw_result_next;

  // Read bookkeeping and result register.
  logic    rd_hit, rd_hit_next;
  logic    res_read, res_read_next;
  logic    out_valid, out_valid_next;
  result_t out_data, out_data_next;

  // Memory ports.
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic              we_ch;
  logic              we_at;
  logic [ADDR_W-1:0] waddr;
  logic [CHAR_W-1:0] wdata_ch;
  logic [ATTR_W-1:0] wdata_at;
  logic [CHAR_W-1:0] ch_rdata;
  logic [ATTR_W-1:0] at_rdata;

  // Cursor arithmetic.
  logic [ADDR_W-1:0] cur_base;
  logic [ADDR_W-1:0] cur_addr;
  logic [C_W-1:0]    col_ext;
  logic [C_W-1:0]    adv;
  logic              step;
  logic              line_feed;
  logic              copy_now;
  logic [COL_W-1:0]  low0;
  logic              hit;

  assign cur_base = ADDR_W'(row) * ADDR_W'(COLUMNS);
  assign cur_addr = cur_base + ADDR_W'(col);
  assign col_ext  = C_W'(col);
  assign hit      = CMP_W'(cmd.cell_index) < CMP_W'(CELLS);
  assign low0     = (CX_W'(cfg.protected_columns) >= CX_W'(COLUMNS - 1)) ?
                    COL_W'(COLUMNS - 1) : COL_W'(cfg.protected_columns);

  assign accept_en    = (state != ST_INIT);
  assign result_valid = out_valid;
  assign result       = out_data;

  tccw_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (we_ch),
    .waddr (waddr),
    .wdata (wdata_ch),
    .re    (re),
    .raddr (raddr),
    .rdata (ch_rdata)
  );

  tccw_ram #(.WIDTH(ATTR_W), .DEPTH(CELLS)) u_attr_ram (
    .clk   (clk),
    .we    (we_at),
    .waddr (waddr),
    .wdata (wdata_at),
    .re    (re),
    .raddr (raddr),
    .rdata (at_rdata)
  );

  // Command sequencer.
  always_comb begin
    state_next       = state;
    col_next         = col;
    row_next         = row;
    scan_col_next    = scan_col;
    scan_low_next    = scan_low;
    sw_ptr_next      = sw_ptr;
    sw_wr_valid_next = sw_wr_valid;
    sw_wr_addr_next  = sw_wr_addr;
    sw_wr_copy_next  = sw_wr_copy;
    sw_scroll_next   = sw_scroll;
    sw_result_next   = sw_result;
    rd_hit_next      = rd_hit;
    res_read_next    = res_read;
    out_valid_next   = out_valid && !result_ready;
    out_data_next    = out_data;
    cmd_ready        = 1'b0;
    re               = 1'b0;
    raddr            = '0;
    we_ch            = 1'b0;
    we_at            = 1'b0;
    waddr            = '0;
    wdata_ch         = '0;
    wdata_at         = '0;
    adv              = '0;
    step             = 1'b0;
    line_feed        = 1'b0;
    copy_now         = 1'b0;

    unique case (state)
      ST_INIT, ST_SWEEP: begin
        // One address a cycle: read the cell one row below and write it in the next
        // cycle, or write blanks.
        if (sw_ptr != PTR_W'(CELLS)) begin
          copy_now         = sw_scroll && (sw_ptr < PTR_W'(CELLS - COLUMNS));
          re               = copy_now;
          raddr            = ADDR_W'(sw_ptr + PTR_W'(COLUMNS));
          sw_wr_addr_next  = ADDR_W'(sw_ptr);
          sw_wr_copy_next  = copy_now;
          sw_wr_valid_next = 1'b1;
          sw_ptr_next      = sw_ptr + PTR_W'(1);
        end else begin
          sw_wr_valid_next = 1'b0;
          if (sw_wr_valid) begin
            state_next = sw_result ? ST_RESULT : ST_IDLE;
          end
        end
        if (sw_wr_valid) begin
          we_ch    = 1'b1;
          we_at    = 1'b1;
          waddr    = sw_wr_addr;
          wdata_ch = sw_wr_copy ? ch_rdata : '0;
          wdata_at = sw_wr_copy ? at_rdata : '0;
        end
      end

      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          res_read_next = 1'b0;
          state_next    = ST_RESULT;
          unique case (cmd.kind)
            KIND_PRINT: begin
              we_ch    = 1'b1;
              we_at    = 1'b1;
              waddr    = cur_addr;
              wdata_ch = cmd.char_code;
              wdata_at = cfg.text_attribute;
              step     = 1'b1;
              adv      = col_ext + C_W'(1);
            end
            KIND_TAB: begin
              step = 1'b1;
              adv  = col_ext + C_W'(cfg.tab_width);
            end
            KIND_RETURN: begin
              col_next = '0;
            end
            KIND_NEWLINE: begin
              col_next  = '0;
              line_feed = 1'b1;
            end
            KIND_BACKSPACE: begin
              if (col != '0 &&
                  (row != '0 || CX_W'(col) >= CX_W'(cfg.protected_columns))) begin
                // Erase the character to the left, keeping its attribute.
                col_next = col - COL_W'(1);
                we_ch    = 1'b1;
                waddr    = cur_addr - ADDR_W'(1);
              end else if (row != '0) begin
                // Move up and search the row above from its right end.
                row_next      = row - ROW_W'(1);
                scan_col_next = COL_W'(COLUMNS - 1);
                scan_low_next = (row == ROW_W'(1)) ? low0 : '0;
                re            = 1'b1;
                raddr         = cur_base - ADDR_W'(1);
                state_next    = ST_SCAN;
              end
            end
            KIND_READ: begin
              re            = 1'b1;
              raddr         = ADDR_W'(cmd.cell_index);
              rd_hit_next   = hit;
              res_read_next = 1'b1;
            end
            KIND_CLEAR: begin
              sw_ptr_next      = '0;
              sw_wr_valid_next = 1'b0;
              sw_scroll_next   = 1'b0;
              sw_result_next   = 1'b1;
              state_next       = ST_SWEEP;
            end
            KIND_NOP: begin
            end
          endcase

          // Column advance with wrap at the row end.
          if (step) begin
            if (adv >= C_W'(COLUMNS)) begin
              col_next  = '0;
              line_feed = 1'b1;
            end else begin
              col_next = COL_W'(adv);
            end
          end

          // Reaching the last row scrolls the screen and keeps the cursor row.
          if (line_feed) begin
            if (row == ROW_W'(ROWS - 2)) begin
              sw_ptr_next      = '0;
              sw_wr_valid_next = 1'b0;
              sw_scroll_next   = 1'b1;
              sw_result_next   = 1'b1;
              state_next       = ST_SWEEP;
            end else begin
              row_next = row + ROW_W'(1);
            end
          end
        end
      end

      ST_SCAN: begin
        // The data for scan_col arrives this cycle.
        if (ch_rdata != '0) begin
          col_next   = (scan_col == COL_W'(COLUMNS - 1)) ? scan_col
                                                         : scan_col + COL_W'(1);
          state_next = ST_RESULT;
        end else if (scan_col == scan_low) begin
          col_next   = scan_low;
          state_next = ST_RESULT;
        end else begin
          scan_col_next = scan_col - COL_W'(1);
          re            = 1'b1;
          raddr         = cur_base + ADDR_W'(scan_col) - ADDR_W'(1);
        end
      end

      ST_RESULT: begin
        if (!out_valid || result_ready) begin
          out_valid_next                = 1'b1;
          out_data_next.cursor_position = POS_W'(cur_addr);
          out_data_next.cell_char       = (res_read && rd_hit) ? ch_rdata : '0;
          out_data_next.cell_attribute  = (res_read && rd_hit) ? at_rdata : '0;
          state_next                    = ST_IDLE;
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      col         <= '0;
      row         <= '0;
      sw_ptr      <= '0;
      sw_wr_valid <= 1'b0;
      sw_scroll   <= 1'b0;
      sw_result   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      col         <= col_next;
      row         <= row_next;
      sw_ptr      <= sw_ptr_next;
      sw_wr_valid <= sw_wr_valid_next;
      sw_scroll   <= sw_scroll_next;
      sw_result   <= sw_result_next;
      out_valid   <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_col   <= scan_col_next;
    scan_low   <= scan_low_next;
    sw_wr_addr <= sw_wr_addr_next;
    sw_wr_copy <= sw_wr_copy_next;
    rd_hit     <= rd_hit_next;
    res_read   <= res_read_next;
    out_data   <= out_data_next;
  end

endmodule

`default_nettype wire

@@ rtl/core/text_console_char_writer.sv @@
// ----------------------------------------------------------------------------
// Text console character writer
// Screen memory of character and attribute cells with a cursor, fed by put,
// read and clear beats, one result beat per input beat.
//
//   Channel   Signals                                 Direction
//   item      item_valid, item_ready, item            in
//   result    result_valid, result_ready, result      out
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  in
//
// Print, return, tab, newline, read and in-row backspace go from the idle
// state to the result state unless they scroll. Backspace at column zero
// searches the row above, one cell a cycle.
// Scroll and clear sweep the whole screen through the single write port.
// After reset a clearing pass over every cell runs; item_ready stays low
// until it ends. Configuration writes are taken at any time.
// A two-beat command queue lets input beats arrive while the back end works
// or while a result waits for result_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer import tccw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic accept_en;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tab_width         <= TAB_RESET;
      cfg.protected_columns <= PROT_RESET;
      cfg.text_attribute    <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TAB_WIDTH: cfg.tab_width         <= cfg_data[TAB_W-1:0];
        CFG_PROTECTED: cfg.protected_columns <= cfg_data[PROT_W-1:0];
        CFG_ATTRIBUTE: cfg.text_attribute    <= cfg_data[ATTR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tccw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept_en  (accept_en),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  tccw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .accept_en    (accept_en)
  );

endmodule

`default_nettype wire

@@ rtl/core/tccw_checker.sv @@
// ----------------------------------------------------------------------------
// Text console port checker
// Watches the top-level ports for result ordering, cursor range and reset
// behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tccw_checker import tccw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // The cursor never rests on the last row.
  localparam int LIMIT = (ROWS - 1) * COLUMNS;

  logic [2:0] pending;

  // Beats accepted but not yet answered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(item_valid && item_ready) - 3'(result_valid && result_ready);
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 3'd0)
    else $error("result beat without an accepted input beat");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (LIMIT > 2047) || (int'(result.cursor_position) < LIMIT))
    else $error("cursor position on or beyond the last row");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !item_ready)
    else $error("ports active right after reset");

endmodule

bind text_console_char_writer tccw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tccw_checker (.*);

`default_nettype wire

@@ dv/text_console_char_writer_test.sv @@
// ----------------------------------------------------------------------------
// Text console character writer testbench
// Drives put, read, clear and unused beats into the console and checks every
// result beat against a hand-typed result or a cycle-free model of the screen,
// cursor and registers. A short directed table opens the run; random bursts of
// text lines, backspaces, tabs and reads follow under several register
// settings and several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_char_writer_test;
  import tccw_pkg::*;

  localparam int COLUMNS = DEF_COLUMNS;
  localparam int ROWS    = DEF_ROWS;
  localparam int CELLS   = ROWS * COLUMNS;

  // Longest quiet stretch a correct run can show is one screen sweep plus
  // stalls, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 20000;
  // Cycles to let a trailing scroll or clear sweep finish.
  localparam int SETTLE_CYCLES = CELLS + 100;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;

  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Register settings per phase; a negative value picks a random one.
  localparam int PHASE_TAB  [PHASES] = '{4, 1, 15, 0, 8, -1, 4, 2};
  localparam int PHASE_PROT [PHASES] = '{16, 0, 79, 127, 40, -1, 16, 1};
  localparam int PHASE_ATTR [PHASES] = '{15, 0, 255, 165, 90, -1, 15, 128};
  // Sender idle and receiver stall percentages, cycled over the phases.
  localparam int IDLE_SEND  [4] = '{0, 74, 0, 11};
  localparam int IDLE_RECV  [4] = '{0, 0, 74, 11};

  // One row of the directed table: the input beat, and a result typed in
  // by hand when the typed flag is set.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    bit                typed;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] cell_ch;
    logic [ATTR_W-1:0] cell_at;
  } step_row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Fresh screen, reads at both ends and past the end, unused operation.
    '{OP_READ,   8'h00,        11'd0,    1'b1, 11'd0,  8'h00, 8'h00},
    '{OP_READ,   8'h00,        11'h7FF,  1'b1, 11'd0,  8'h00, 8'h00},
    '{OP_READ,   8'hFF,        11'd1999, 1'b1, 11'd0,  8'h00, 8'h00},
    '{OP_UNUSED, 8'hFF,        11'h7FF,  1'b1, 11'd0,  8'h00, 8'h00},
    // Print and read back with the reset attribute.
    '{OP_PUT,    8'h41,        11'd0,    1'b1, 11'd1,  8'h00, 8'h00},
    '{OP_READ,   8'h00,        11'd0,    1'b1, 11'd1,  8'h41, 8'h0F},
    // Backspace inside the protected prompt does nothing.
    '{OP_PUT,    CH_BACKSPACE, 11'd0,    1'b1, 11'd1,  8'h00, 8'h00},
    '{OP_PUT,    CH_TAB,       11'd0,    1'b1, 11'd5,  8'h00, 8'h00},
    '{OP_PUT,    8'hFF,        11'h7FF,  1'b1, 11'd6,  8'h00, 8'h00},
    '{OP_PUT,    CH_NEWLINE,   11'd0,    1'b1, 11'd80, 8'h00, 8'h00},
    // Up to row zero, nothing right of the prompt: land on the prompt end.
    '{OP_PUT,    CH_BACKSPACE, 11'd0,    1'b1, 11'd16, 8'h00, 8'h00},
    // Printing a zero byte leaves a blank cell.
    '{OP_PUT,    8'h00,        11'd0,    1'b0, 11'd0,  8'h00, 8'h00},
    '{OP_PUT,    CH_BACKSPACE, 11'd0,    1'b0, 11'd0,  8'h00, 8'h00},
    '{OP_PUT,    CH_BACKSPACE, 11'd0,    1'b0, 11'd0,  8'h00, 8'h00},
    '{OP_PUT,    CH_RETURN,    11'd0,    1'b0, 11'd0,  8'h00, 8'h00},
    '{OP_PUT,    CH_NEWLINE,   11'd0,    1'b0, 11'd0,  8'h00, 8'h00},
    '{OP_PUT,    8'h7E,        11'd0,    1'b0, 11'd0,  8'h00, 8'h00},
    '{OP_PUT,    CH_RETURN,    11'd0,    1'b0, 11'd0,  8'h00, 8'h00},
    '{OP_PUT,    CH_BACKSPACE, 11'd0,    1'b0, 11'd0,  8'h00, 8'h00},
    '{OP_PUT,    CH_NEWLINE,   11'd0,    1'b0, 11'd0,  8'h00, 8'h00},
    '{OP_PUT,    CH_NEWLINE,   11'd0,    1'b0, 11'd0,  8'h00, 8'h00},
    // Backspace from column zero onto a row above that is not row zero.
    '{OP_PUT,    CH_BACKSPACE, 11'd0,    1'b0, 11'd0,  8'h00, 8'h00},
    '{OP_CLEAR,  8'hFF,        11'h7FF,  1'b0, 11'd0,  8'h00, 8'h00},
    '{OP_READ,   8'h00,        11'd80,   1'b0, 11'd0,  8'h00, 8'h00}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Screen model and its register copies.
  logic [CHAR_W-1:0] screen_char [CELLS];
  logic [ATTR_W-1:0] screen_attr [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [TAB_W-1:0]  tab_width;
  logic [PROT_W-1:0] prompt_cols;
  logic [ATTR_W-1:0] text_attr;

  result_t console_replies [$];
  int      items_sent;
  int      mismatches;
  int      quiet_cycles;
  int      send_idle;
  int      recv_stall;

  text_console_char_writer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shift every row up by one and blank the bottom row.
  function automatic void scroll_up();
    for (int i = 0; i < CELLS - COLUMNS; i++) begin
      screen_char[i] = screen_char[i + COLUMNS];
      screen_attr[i] = screen_attr[i + COLUMNS];
    end
    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
      screen_char[i] = '0;
      screen_attr[i] = '0;
    end
    if (cur_row > 0) cur_row--;
  endfunction

  // Erase within the row, or climb to the end of the text on the row above.
  function automatic void erase_back();
    int unsigned base;
    int unsigned lowest;
    int unsigned land;
    if (cur_col > 0 && (cur_row > 0 || cur_col >= prompt_cols)) begin
      cur_col--;
      screen_char[cur_row * COLUMNS + cur_col] = '0;
      return;
    end
    if (cur_row == 0) return;
    cur_row--;
    base = cur_row * COLUMNS;
    lowest = 0;
    if (cur_row == 0) lowest = (prompt_cols < COLUMNS - 1) ? prompt_cols : COLUMNS - 1;
    land = lowest;
    for (int unsigned c = COLUMNS; c > lowest; c--) begin
      if (screen_char[base + c - 1] != '0) begin
        land = c;
        break;
      end
    end
    if (land > COLUMNS - 1) land = COLUMNS - 1;
    cur_col = land;
  endfunction

  // Apply one input beat to the screen model and return the result it gives.
  function automatic result_t console_step(input item_t it);
    result_t     res;
    int unsigned pos;
    res = '0;
    case (it.operation)
      OP_PUT: begin
        case (it.char_code)
          CH_BACKSPACE: erase_back();
          CH_RETURN:    cur_col = 0;
          CH_TAB:       cur_col += tab_width;
          CH_NEWLINE: begin
            cur_col = 0;
            cur_row++;
          end
          default: begin
            pos = cur_row * COLUMNS + cur_col;
            if (pos < CELLS) begin
              screen_char[pos] = it.char_code;
              screen_attr[pos] = text_attr;
            end
            cur_col++;
          end
        endcase
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS - 1) scroll_up();
      end
      OP_READ: begin
        if (it.cell_index < CELLS) begin
          res.cell_char      = screen_char[it.cell_index];
          res.cell_attribute = screen_attr[it.cell_index];
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_char[i] = '0;
          screen_attr[i] = '0;
        end
      end
      default: ;
    endcase
    res.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  // Offer one beat after any random idle, and queue its expected result.
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    result_t got;
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    got = console_step(it);
    console_replies.push_back(typed ? want : got);
    items_sent++;
  endtask

  task automatic send_put(input logic [CHAR_W-1:0] ch);
    item_t it;
    it.operation  = OP_PUT;
    it.char_code  = ch;
    it.cell_index = IDX_W'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  // Valid stays high between back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TAB_WIDTH: tab_width = data[TAB_W-1:0];
      CFG_PROTECTED: prompt_cols = data[PROT_W-1:0];
      CFG_ATTRIBUTE: text_attr = data;
      default: ;
    endcase
  endtask

  // Wait for every result, then for any trailing sweep to finish.
  task automatic drain();
    item_valid <= 1'b0;
    while (console_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random bursts: mostly text lines and editing, with reads and some noise.
  task automatic random_traffic(input int goal);
    int    kind;
    int    near;
    item_t it;
    while (items_sent < goal) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        repeat (($urandom_range(3) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 40))
          send_put(($urandom_range(7) == 0) ? CHAR_W'($urandom_range(255))
                                            : CHAR_W'($urandom_range(32, 126)));
        case ($urandom_range(3))
          0: send_put(CH_NEWLINE);
          1: begin
            send_put(CH_RETURN);
            send_put(CH_NEWLINE);
          end
          default: ;
        endcase
      end else if (kind < 60) begin
        repeat ($urandom_range(1, 10)) send_put(CH_BACKSPACE);
      end else if (kind < 68) begin
        repeat ($urandom_range(1, 8)) send_put(CH_TAB);
      end else if (kind < 72) begin
        send_put(CH_RETURN);
      end else if (kind < 86) begin
        repeat ($urandom_range(1, 4)) begin
          near = int'(cur_row * COLUMNS + cur_col) - int'($urandom_range(0, 100));
          if (near < 0 || $urandom_range(3) == 0) near = $urandom_range(0, 2047);
          it.operation  = OP_READ;
          it.char_code  = CHAR_W'($urandom);
          it.cell_index = IDX_W'(near);
          send_item(it, 1'b0, '0);
        end
      end else if (kind < 88) begin
        it.operation  = OP_CLEAR;
        it.char_code  = CHAR_W'($urandom);
        it.cell_index = IDX_W'($urandom);
        send_item(it, 1'b0, '0);
      end else begin
        // Noise: any byte put, any read, or the unused operation.
        case ($urandom_range(2))
          0:       it.operation = OP_PUT;
          1:       it.operation = OP_READ;
          default: it.operation = OP_UNUSED;
        endcase
        it.char_code  = CHAR_W'($urandom);
        it.cell_index = IDX_W'($urandom);
        send_item(it, 1'b0, '0);
      end
    end
  endtask

  // Receiver: stall at random, check each result beat, and watch for hangs.
  always @(posedge clk) begin
    result_t want;
    result_ready <= ($urandom_range(99) >= recv_stall);
    if (!rst) begin
      if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
      if (result_valid && result_ready) begin
        if (console_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: pos %0d char %02h attr %02h",
                     result.cursor_position, result.cell_char, result.cell_attribute);
        end else begin
          want = console_replies.pop_front();
          if (result.cursor_position !== want.cursor_position ||
              result.cell_char !== want.cell_char ||
              result.cell_attribute !== want.cell_attribute) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want pos %0d ch %02h at %02h, got pos %0d ch %02h at %02h",
                       want.cursor_position, want.cell_char, want.cell_attribute,
                       result.cursor_position, result.cell_char, result.cell_attribute);
          end
        end
      end
    end
  end

  initial begin
    item_t   it;
    result_t want;
    int      tab;
    int      prot;
    int      attr;
    for (int i = 0; i < CELLS; i++) begin
      screen_char[i] = '0;
      screen_attr[i] = '0;
    end
    cur_col = 0;
    cur_row = 0;
    tab_width = TAB_RESET;
    prompt_cols = PROT_RESET;
    text_attr = ATTR_RESET;
    items_sent = 0;
    mismatches = 0;
    quiet_cycles = 0;
    send_idle = 0;
    recv_stall = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table at reset settings, no idling.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      it.operation  = DIRECTED[r].op;
      it.char_code  = DIRECTED[r].ch;
      it.cell_index = DIRECTED[r].idx;
      want.cursor_position = DIRECTED[r].pos;
      want.cell_char       = DIRECTED[r].cell_ch;
      want.cell_attribute  = DIRECTED[r].cell_at;
      send_item(it, DIRECTED[r].typed, want);
    end
    drain();

    // Random phases, each under its own register setting and idle pattern.
    for (int p = 0; p < PHASES; p++) begin
      tab  = (PHASE_TAB[p] < 0) ? $urandom_range(15) : PHASE_TAB[p];
      prot = (PHASE_PROT[p] < 0) ? $urandom_range(127) : PHASE_PROT[p];
      attr = (PHASE_ATTR[p] < 0) ? $urandom_range(255) : PHASE_ATTR[p];
      write_reg(CFG_TAB_WIDTH, {4'($urandom), 4'(tab)});
      write_reg(CFG_PROTECTED, {1'($urandom), 7'(prot)});
      write_reg(CFG_ATTRIBUTE, 8'(attr));
      write_reg(CFG_UNUSED, 8'($urandom));
      cfg_valid <= 1'b0;
      send_idle = IDLE_SEND[p % 4];
      recv_stall = IDLE_RECV[p % 4];
      random_traffic(items_sent + ITEMS_PER_PHASE);
      drain();
      recv_stall = 0;
    end

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
